// File: rtl/multi_channel_blink_pattern_generator_core_defines.svh
// assertion macros for the blink pattern generator
`ifndef MULTI_CHANNEL_BLINK_PATTERN_GENERATOR_CORE_DEFINES_SVH
`define MULTI_CHANNEL_BLINK_PATTERN_GENERATOR_CORE_DEFINES_SVH

// same-cycle implication, checked outside reset
`define MCBPG_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("blink generator check failed");

// next-cycle implication, checked outside reset
`define MCBPG_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("blink generator check failed");

`endif

// File: rtl/mcbpg_pkg.sv
// shared types and constants of the blink pattern generator
`default_nettype none

package mcbpg_pkg;

  typedef enum logic [1:0] {
    OP_TICK  = 2'd0,
    OP_START = 2'd1,
    OP_STOP  = 2'd2,
    OP_UNDEF = 2'd3
  } op_t;

  typedef struct packed {
    logic busy;
    logic done;
  } div_stat_t;

  localparam int          DIVIDEND_BITS = 33;
  localparam logic [31:0] ELAPSED_MAX   = 32'hFFFF_FFFF;
  localparam logic [63:0] ON_RESET      = 64'h0001_0101_0102_0000;
  localparam logic [63:0] CYCLE_RESET   = 64'd3108366801174528;

  // run limit held by each channel after reset
  function automatic logic [31:0] limit_reset(input logic [2:0] idx);
    logic [31:0] val;
    unique case (idx)
      3'd2:                     val = 32'h0000_FFFF;
      3'd3, 3'd4, 3'd5, 3'd6:   val = 32'd22;
      default:                  val = 32'd0;
    endcase
    return val;
  endfunction

endpackage

`default_nettype wire

// File: rtl/mcbpg_mod.sv
// bit-serial remainder unit: one dividend bit per cycle
`default_nettype none

module mcbpg_mod #(
  parameter int DIV_BITS = 8
) (
  input  wire logic                                   clk,
  input  wire logic                                   rst,
  input  wire logic                                   start,
  input  wire logic [mcbpg_pkg::DIVIDEND_BITS-1:0]    dividend,
  input  wire logic [DIV_BITS-1:0]                    divisor,
  output mcbpg_pkg::div_stat_t                        stat,
  output logic      [DIV_BITS-1:0]                    remainder
);

  localparam int CNT_BITS = $clog2(mcbpg_pkg::DIVIDEND_BITS);

  logic                                busy;
  logic                                done;
  logic [CNT_BITS-1:0]                 cnt;
  logic [mcbpg_pkg::DIVIDEND_BITS-1:0] shreg;
  logic [DIV_BITS-1:0]                 div_q;
  logic [DIV_BITS-1:0]                 rem;
  logic [DIV_BITS:0]                   trial;
  logic [DIV_BITS:0]                   trial_sub;
  logic                                fits;

  // shift the next dividend bit in, subtract when it fits
  always_comb begin
    trial     = {rem, shreg[mcbpg_pkg::DIVIDEND_BITS-1]};
    fits      = (trial >= {1'b0, div_q});
    trial_sub = trial - {1'b0, div_q};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      if (start) begin
        busy <= 1'b1;
        done <= 1'b0;
        cnt  <= CNT_BITS'(mcbpg_pkg::DIVIDEND_BITS - 1);
      end else if (busy) begin
        if (cnt == '0) begin
          busy <= 1'b0;
          done <= 1'b1;
        end else begin
          done <= 1'b0;
          cnt  <= cnt - 1'b1;
        end
      end else begin
        done <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      shreg <= dividend;
      div_q <= divisor;
      rem   <= '0;
    end else if (busy) begin
      shreg <= shreg << 1;
      rem   <= fits ? trial_sub[DIV_BITS-1:0] : trial[DIV_BITS-1:0];
    end
  end

  assign stat.busy = busy;
  assign stat.done = done;
  assign remainder = rem;

endmodule

`default_nettype wire

// File: rtl/multi_channel_blink_pattern_generator_core.sv
// top level of the multi-channel blink pattern generator
// start, stop and undefined requests go from acceptance straight to the finish step
// tick: idle channels are skipped; a running channel with a nonzero cycle waits for a
// bit-serial remainder over the 33-bit dividend, and one with no cycle does not
// one request at a time; the next request is taken while the previous result waits
// reset is synchronous; channel state comes from per-entry valid bits, so no clearing pass
`default_nettype none

module multi_channel_blink_pattern_generator_core #(
  parameter int CHANNELS     = 8,
  parameter int PATTERN_BITS = 8
) (
  input  wire logic        clk,
  input  wire logic        rst,
  // configuration write port
  input  wire logic        cfg_write,
  input  wire logic        cfg_index,
  input  wire logic [63:0] cfg_data,
  // request channel
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic [1:0]  opcode,
  input  wire logic [2:0]  channel,
  input  wire logic [31:0] run_ticks,
  // result channel
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic [7:0]       turn_on_mask,
  output logic [7:0]       turn_off_mask,
  output logic [7:0]       active_mask,
  output logic             bad_request
);

  localparam int CH_BITS  = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
  localparam int CNT_W    = 32 + PATTERN_BITS;

  // one-hot sequencer
  typedef enum logic [5:0] {
    ST_IDLE   = 6'b000001,
    ST_SCAN   = 6'b000010,
    ST_CALC   = 6'b000100,
    ST_DIV    = 6'b001000,
    ST_WRITE  = 6'b010000,
    ST_FINISH = 6'b100000
  } state_t;

  state_t state;

  // configuration registers
  logic [63:0] on_times_packed;
  logic [63:0] cycle_lengths_packed;

  always_ff @(posedge clk) begin
    if (rst) begin
      on_times_packed      <= mcbpg_pkg::ON_RESET;
      cycle_lengths_packed <= mcbpg_pkg::CYCLE_RESET;
    end else if (cfg_write) begin
      if (cfg_index == 1'b0) begin
        on_times_packed <= cfg_data;
      end else begin
        cycle_lengths_packed <= cfg_data;
      end
    end
  end

  // request acceptance
  logic in_fire;
  logic ch_in_range;
  logic [CH_BITS-1:0] ch_idx;

  assign in_stall    = (state != ST_IDLE);
  assign in_fire     = in_valid && !in_stall;
  assign ch_in_range = ({1'b0, channel} < 4'(CHANNELS));
  assign ch_idx      = channel[CH_BITS-1:0];

  // per-channel state memories: run limit, and elapsed count with phase
  // an entry never written reads as its reset value through its valid bit
  logic [31:0]    lim_mem [CHANNELS];
  logic [CNT_W-1:0] cnt_mem [CHANNELS];
  logic [CHANNELS-1:0] lim_vld;
  logic [CHANNELS-1:0] cnt_vld;
  logic [31:0]    lim_rd;
  logic [CNT_W-1:0] cnt_rd;
  logic           lim_rd_vld;
  logic           cnt_rd_vld;

  logic [CHANNELS-1:0] running;
  logic [CH_BITS-1:0]  k;          // channel being visited by a tick
  logic                last_ch;
  logic                bad_q;
  logic [7:0]          on_acc;
  logic [7:0]          off_acc;
  logic [31:0]         elapsed_new;
  logic [PATTERN_BITS-1:0] phase_new;

  logic start_wr;
  logic cnt_wr;

  assign last_ch  = (k == CH_BITS'(CHANNELS - 1));
  assign start_wr = in_fire && (mcbpg_pkg::op_t'(opcode) == mcbpg_pkg::OP_START) && ch_in_range;
  assign cnt_wr   = (state == ST_WRITE);

  // sequencer visits one entry at a time, so a write back never overlaps a read of it
  always_ff @(posedge clk) begin
    if (start_wr) begin
      lim_mem[ch_idx] <= run_ticks;
    end
    if (cnt_wr) begin
      cnt_mem[k] <= {elapsed_new, phase_new};
    end
    lim_rd <= lim_mem[k];
    cnt_rd <= cnt_mem[k];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      lim_vld    <= '0;
      cnt_vld    <= '0;
      lim_rd_vld <= 1'b0;
      cnt_rd_vld <= 1'b0;
    end else begin
      if (start_wr) begin
        lim_vld[ch_idx] <= 1'b1;
      end
      if (cnt_wr) begin
        cnt_vld[k] <= 1'b1;
      end
      lim_rd_vld <= lim_vld[k];
      cnt_rd_vld <= cnt_vld[k];
    end
  end

  // read-data view with reset values for entries never written
  logic [31:0]             lim_eff;
  logic [31:0]             elapsed_old;
  logic [PATTERN_BITS-1:0] phase_old;
  logic [31:0]             elapsed_inc;
  logic [PATTERN_BITS-1:0] on_field;
  logic [PATTERN_BITS-1:0] cyc_field;
  logic [mcbpg_pkg::DIVIDEND_BITS-1:0] dividend;

  always_comb begin
    lim_eff     = lim_rd_vld ? lim_rd : mcbpg_pkg::limit_reset(3'(k));
    elapsed_old = cnt_rd_vld ? cnt_rd[CNT_W-1:PATTERN_BITS] : 32'd0;
    phase_old   = cnt_rd_vld ? cnt_rd[PATTERN_BITS-1:0] : '0;
    // saturating increment
    elapsed_inc = (elapsed_old == mcbpg_pkg::ELAPSED_MAX) ? elapsed_old : elapsed_old + 32'd1;
    on_field    = on_times_packed[{k, 3'b000} +: PATTERN_BITS];
    cyc_field   = cycle_lengths_packed[{k, 3'b000} +: PATTERN_BITS];
    // phase uses the full count plus one, no wrap
    dividend    = {1'b0, elapsed_inc} + 33'd1;
  end

  // remainder unit
  mcbpg_pkg::div_stat_t div_stat;
  logic                    div_start;
  logic [PATTERN_BITS-1:0] div_rem;

  assign div_start = (state == ST_CALC) && (cyc_field != '0);

  mcbpg_mod #(
    .DIV_BITS (PATTERN_BITS)
  ) u_mod (
    .clk       (clk),
    .rst       (rst),
    .start     (div_start),
    .dividend  (dividend),
    .divisor   (cyc_field),
    .stat      (div_stat),
    .remainder (div_rem)
  );

  // output register is free when empty or being taken this cycle
  logic out_free;
  assign out_free = !out_valid || !out_stall;

  logic [7:0] run_view;
  always_comb begin
    run_view = '0;
    run_view[CHANNELS-1:0] = running;
  end

  // main sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      running   <= '0;
      k         <= '0;
      bad_q     <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      // a new result loads as the old one leaves, otherwise a taken result empties it
      if ((state == ST_FINISH) && out_free) begin
        out_valid <= 1'b1;
      end else if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        ST_IDLE: begin
          if (in_fire) begin
            bad_q <= 1'b0;
            k     <= '0;
            unique case (mcbpg_pkg::op_t'(opcode))
              mcbpg_pkg::OP_TICK: begin
                state <= ST_SCAN;
              end
              mcbpg_pkg::OP_START: begin
                if (ch_in_range) begin
                  running[ch_idx] <= 1'b1;
                end
                state <= ST_FINISH;
              end
              mcbpg_pkg::OP_STOP: begin
                if (ch_in_range) begin
                  running[ch_idx] <= 1'b0;
                end
                state <= ST_FINISH;
              end
              mcbpg_pkg::OP_UNDEF: begin
                bad_q <= 1'b1;
                state <= ST_FINISH;
              end
              default: begin
                state <= ST_FINISH;
              end
            endcase
          end
        end
        ST_SCAN: begin
          // idle channels are skipped; the read of entry k lands next cycle
          if (running[k]) begin
            state <= ST_CALC;
          end else if (last_ch) begin
            state <= ST_FINISH;
          end else begin
            k <= k + 1'b1;
          end
        end
        ST_CALC: begin
          elapsed_new <= elapsed_inc;
          if (elapsed_inc >= lim_eff) begin
            running[k] <= 1'b0;
          end
          if (cyc_field == '0) begin
            phase_new <= '0;
            state     <= ST_WRITE;
          end else begin
            state <= ST_DIV;
          end
        end
        ST_DIV: begin
          if (div_stat.done) begin
            phase_new <= div_rem;
            state     <= ST_WRITE;
          end
        end
        ST_WRITE: begin
          if (last_ch) begin
            state <= ST_FINISH;
          end else begin
            k     <= k + 1'b1;
            state <= ST_SCAN;
          end
        end
        ST_FINISH: begin
          if (out_free) begin
            state <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  // turn-on and turn-off masks collected over one tick
  always_ff @(posedge clk) begin
    if (in_fire) begin
      on_acc  <= '0;
      off_acc <= '0;
    end else if (state == ST_CALC) begin
      if (phase_old == '0) begin
        on_acc <= on_acc | (8'd1 << k);
      end
      if (phase_old == on_field) begin
        off_acc <= off_acc | (8'd1 << k);
      end
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if ((state == ST_FINISH) && out_free) begin
      turn_on_mask  <= on_acc;
      turn_off_mask <= off_acc;
      active_mask   <= run_view;
      bad_request   <= bad_q;
    end
  end

`include "multi_channel_blink_pattern_generator_core_defines.svh"

  // an undefined request never carries turn-on or turn-off bits
  `MCBPG_ASSERT_NOW(a_bad_no_masks, out_valid && bad_request, (turn_on_mask | turn_off_mask) == 8'd0)
  // the remainder unit is quiet whenever the sequencer waits for a request
  `MCBPG_ASSERT_NOW(a_div_idle, state == ST_IDLE, !div_stat.busy)
  // a remainder is only started from the calculate step and runs in the divide wait
  `MCBPG_ASSERT_NEXT(a_div_start_wait, div_start, (state == ST_DIV) && div_stat.busy)
  // no channel beyond the configured count is ever reported active
  `MCBPG_ASSERT_NOW(a_active_range, out_valid, (active_mask >> CHANNELS) == 8'd0)

endmodule

`default_nettype wire

// File: tb/mcbpg_checker.sv
// checker for the blink pattern generator: channel model, expected result queue, compare
`default_nettype none

module mcbpg_checker #(
  parameter int CHANNELS     = 8,
  parameter int PATTERN_BITS = 8,
  parameter bit ON_TIMES_REG = 1'b0,
  parameter bit CYCLES_REG   = 1'b1
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        cfg_write,
  input  wire logic        cfg_index,
  input  wire logic [63:0] cfg_data,
  input  wire logic        in_valid,
  input  wire logic        in_stall,
  input  wire logic [1:0]  opcode,
  input  wire logic [2:0]  channel,
  input  wire logic [31:0] run_ticks,
  input  wire logic        out_valid,
  input  wire logic        out_stall,
  input  wire logic [7:0]  turn_on_mask,
  input  wire logic [7:0]  turn_off_mask,
  input  wire logic [7:0]  active_mask,
  input  wire logic        bad_request,
  output int               errors,
  output int               pending
);

  typedef struct packed {
    logic [7:0] turn_on;
    logic [7:0] turn_off;
    logic [7:0] active;
    logic       bad;
  } blink_result_t;

  localparam logic [7:0]  FIELD_MASK = 8'((1 << PATTERN_BITS) - 1);
  localparam logic [31:0] LIMIT_AT_RESET [8] = '{
    32'd0, 32'd0, 32'h0000_FFFF, 32'd22, 32'd22, 32'd22, 32'd22, 32'd0
  };

  logic [63:0]   on_times;
  logic [63:0]   cycle_lengths;
  logic [7:0]    running;
  logic [31:0]   limit_of [8];
  logic [31:0]   elapsed_of [8];
  logic [7:0]    phase_of [8];
  blink_result_t due_results [$];
  int            mismatch_count = 0;
  int            waiting = 0;

  assign errors  = mismatch_count;
  assign pending = waiting;

  task automatic report(input string what, input logic [31:0] want, input logic [31:0] got);
    $display("mismatch %s: expected %0h got %0h at %0t", what, want, got, $time);
    mismatch_count++;
  endtask

  function automatic logic [7:0] byte_field(input logic [63:0] word, input int k);
    return word[8*k +: 8] & FIELD_MASK;
  endfunction

  // apply one request to the channel model and return the outputs it gives
  task automatic serve_request(input mcbpg_pkg::op_t op, input logic [2:0] ch,
                               input logic [31:0] ticks, output blink_result_t res);
    logic [7:0]  on_t;
    logic [7:0]  cyc;
    logic [32:0] nxt;
    res = '0;
    case (op)
      mcbpg_pkg::OP_TICK: begin
        for (int k = 0; k < CHANNELS; k++) begin
          if (running[k]) begin
            if (elapsed_of[k] != mcbpg_pkg::ELAPSED_MAX) elapsed_of[k] = elapsed_of[k] + 32'd1;
            if (elapsed_of[k] >= limit_of[k]) running[k] = 1'b0;
            on_t = byte_field(on_times, k);
            cyc  = byte_field(cycle_lengths, k);
            if (phase_of[k] == 8'd0) res.turn_on[k] = 1'b1;
            if (phase_of[k] == on_t) res.turn_off[k] = 1'b1;
            // phase from the full count plus one, no wrap at saturation
            nxt = {1'b0, elapsed_of[k]} + 33'd1;
            phase_of[k] = (cyc == 8'd0) ? 8'd0 : 8'(nxt % {25'd0, cyc});
          end
        end
      end
      mcbpg_pkg::OP_START: begin
        if (ch < CHANNELS) begin
          limit_of[ch] = ticks;
          running[ch]  = 1'b1;
        end
      end
      mcbpg_pkg::OP_STOP: begin
        if (ch < CHANNELS) running[ch] = 1'b0;
      end
      default: res.bad = 1'b1;
    endcase
    res.active = running;
  endtask

  always @(posedge clk) begin : watch
    blink_result_t want;
    blink_result_t got;
    if (rst) begin
      on_times      = mcbpg_pkg::ON_RESET;
      cycle_lengths = mcbpg_pkg::CYCLE_RESET;
      running       = '0;
      for (int k = 0; k < 8; k++) begin
        limit_of[k]   = LIMIT_AT_RESET[k];
        elapsed_of[k] = '0;
        phase_of[k]   = '0;
      end
      due_results.delete();
    end else begin
      if (out_valid && !out_stall) begin
        got = '{turn_on_mask, turn_off_mask, active_mask, bad_request};
        if (due_results.size() == 0) begin
          report("result with no request waiting", '0, 32'(got));
        end else begin
          want = due_results.pop_front();
          if (got.turn_on !== want.turn_on)
            report("turn_on_mask", 32'(want.turn_on), 32'(got.turn_on));
          if (got.turn_off !== want.turn_off)
            report("turn_off_mask", 32'(want.turn_off), 32'(got.turn_off));
          if (got.active !== want.active)
            report("active_mask", 32'(want.active), 32'(got.active));
          if (got.bad !== want.bad)
            report("bad_request", 32'(want.bad), 32'(got.bad));
        end
      end
      if (in_valid && !in_stall) begin
        serve_request(mcbpg_pkg::op_t'(opcode), channel, run_ticks, want);
        due_results.push_back(want);
      end
      if (cfg_write) begin
        if (cfg_index == ON_TIMES_REG) on_times = cfg_data;
        else if (cfg_index == CYCLES_REG) cycle_lengths = cfg_data;
      end
    end
    waiting = due_results.size();
  end

endmodule

`default_nettype wire

// File: tb/multi_channel_blink_pattern_generator_core_tb.sv
// testbench top: stimulus, handshake pacing, register phases and verdict
`default_nettype none

module multi_channel_blink_pattern_generator_core_tb;

  // register indexes of the configuration port
  localparam bit REG_ON_TIMES      = 1'b0;
  localparam bit REG_CYCLE_LENGTHS = 1'b1;

  localparam int GAP_MAX            = 6;
  localparam int REQUESTS_PER_PHASE = 300;
  // allows for the worst tick, which walks eight running channels, plus stalls
  localparam int QUIET_LIMIT        = 4000;
  localparam int DRAIN_CYCLES       = 400;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        cfg_write = 1'b0;
  logic        cfg_index = 1'b0;
  logic [63:0] cfg_data = '0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [1:0]  opcode = mcbpg_pkg::OP_TICK;
  logic [2:0]  channel = '0;
  logic [31:0] run_ticks = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [7:0]  turn_on_mask;
  logic [7:0]  turn_off_mask;
  logic [7:0]  active_mask;
  logic        bad_request;
  int          errors;
  int          pending;

  multi_channel_blink_pattern_generator_core u_top (
    .clk(clk), .rst(rst),
    .cfg_write(cfg_write), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .in_valid(in_valid), .in_stall(in_stall),
    .opcode(opcode), .channel(channel), .run_ticks(run_ticks),
    .out_valid(out_valid), .out_stall(out_stall),
    .turn_on_mask(turn_on_mask), .turn_off_mask(turn_off_mask),
    .active_mask(active_mask), .bad_request(bad_request)
  );

  mcbpg_checker #(
    .ON_TIMES_REG(REG_ON_TIMES),
    .CYCLES_REG(REG_CYCLE_LENGTHS)
  ) u_check (
    .clk(clk), .rst(rst),
    .cfg_write(cfg_write), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .in_valid(in_valid), .in_stall(in_stall),
    .opcode(opcode), .channel(channel), .run_ticks(run_ticks),
    .out_valid(out_valid), .out_stall(out_stall),
    .turn_on_mask(turn_on_mask), .turn_off_mask(turn_off_mask),
    .active_mask(active_mask), .bad_request(bad_request),
    .errors(errors), .pending(pending)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // watchdog: too long with no request or result moving means the block hung
  int quiet = 0;
  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      quiet <= 0;
    end else if (quiet >= QUIET_LIMIT) begin
      $display("FAIL multi_channel_blink_pattern_generator_core");
      $finish;
    end else begin
      quiet <= quiet + 1;
    end
  end

  // result side back-pressure: after each taken result draw how many cycles
  // of the next valid result to hold off; runs of zero stalls come and go
  logic took = 1'b0;
  logic saw_valid = 1'b0;
  int   hold = 0;
  bit   out_burst = 1'b0;

  always @(posedge clk) begin
    took      <= out_valid && !out_stall;
    saw_valid <= out_valid;
  end

  always @(negedge clk) begin
    if (took) begin
      if ($urandom_range(0, 39) == 0) out_burst = !out_burst;
      hold = out_burst ? 0 : $urandom_range(0, GAP_MAX);
    end else if (saw_valid && hold > 0) begin
      hold--;
    end
    out_stall <= (hold > 0);
  end

  // request side pacing: a random gap before each request, or none in a burst
  bit in_burst = 1'b0;

  // called and returning at a falling edge
  task automatic send_request(input mcbpg_pkg::op_t op, input logic [2:0] ch,
                              input logic [31:0] ticks);
    int gap;
    gap = in_burst ? 0 : $urandom_range(0, GAP_MAX);
    if (gap > 0) begin
      in_valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    opcode    = op;
    channel   = ch;
    run_ticks = ticks;
    in_valid  = 1'b1;
    do @(posedge clk); while (in_stall);
    @(negedge clk);
    if ($urandom_range(0, 39) == 0) in_burst = !in_burst;
  endtask

  // registers change only with the block idle: every request gives a result,
  // so no result outstanding means nothing is in progress
  task automatic write_reg(input logic idx, input logic [63:0] value);
    in_valid = 1'b0;
    while (pending != 0) @(negedge clk);
    cfg_index = idx;
    cfg_data  = value;
    cfg_write = 1'b1;
    @(negedge clk);
    cfg_write = 1'b0;
  endtask

  // run lengths: mostly short so channels finish and get restarted
  function automatic logic [31:0] pick_run_ticks();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return 32'($urandom_range(0, 12));
    if (r < 75) return 32'($urandom_range(13, 300));
    if (r < 85) return $urandom;
    if (r < 90) return 32'd0;
    if (r < 95) return 32'hFFFF_FFFF;
    return 32'($urandom_range(1, 3));
  endfunction

  // undefined opcodes are noise and do not count toward the phase
  task automatic random_phase(input int count);
    int          issued;
    int          pick;
    logic [2:0]  ch;
    issued = 0;
    while (issued < count) begin
      pick = $urandom_range(0, 99);
      ch   = 3'($urandom_range(0, 7));
      if (pick < 45) begin
        send_request(mcbpg_pkg::OP_TICK, ch, $urandom);
        issued++;
      end else if (pick < 80) begin
        send_request(mcbpg_pkg::OP_START, ch, pick_run_ticks());
        issued++;
      end else if (pick < 92) begin
        send_request(mcbpg_pkg::OP_STOP, ch, $urandom);
        issued++;
      end else begin
        send_request(mcbpg_pkg::OP_UNDEF, ch, $urandom);
      end
    end
  endtask

  initial begin : stimulus
    logic [63:0] on_word;
    logic [63:0] cycle_word;
    repeat (11) @(negedge clk);
    rst = 1'b0;

    // directed part, reset register values
    send_request(mcbpg_pkg::OP_TICK, 3'd0, 32'd0);           // tick with nothing running
    send_request(mcbpg_pkg::OP_UNDEF, 3'd7, 32'hFFFF_FFFF);  // undefined opcode, all ones
    send_request(mcbpg_pkg::OP_UNDEF, 3'd0, 32'd0);          // undefined opcode, all zeros
    send_request(mcbpg_pkg::OP_START, 3'd0, 32'd0);          // zero limit runs one tick
    send_request(mcbpg_pkg::OP_TICK, 3'd0, 32'd0);
    send_request(mcbpg_pkg::OP_TICK, 3'd0, 32'd0);
    send_request(mcbpg_pkg::OP_START, 3'd7, 32'hFFFF_FFFF);  // longest run on the top channel
    send_request(mcbpg_pkg::OP_START, 3'd2, 32'd3);
    repeat (4) send_request(mcbpg_pkg::OP_TICK, 3'd5, 32'hFFFF_FFFF);
    // restart below the elapsed count: channel stops on its next tick
    send_request(mcbpg_pkg::OP_START, 3'd2, 32'd1);
    send_request(mcbpg_pkg::OP_TICK, 3'd0, 32'd0);
    send_request(mcbpg_pkg::OP_STOP, 3'd7, 32'd0);
    send_request(mcbpg_pkg::OP_STOP, 3'd7, 32'hFFFF_FFFF);   // stop of an idle channel
    for (int k = 0; k < 8; k++) send_request(mcbpg_pkg::OP_START, 3'(k), 32'(k + 2));
    send_request(mcbpg_pkg::OP_TICK, 3'd0, 32'd0);
    send_request(mcbpg_pkg::OP_TICK, 3'd0, 32'd0);

    random_phase(REQUESTS_PER_PHASE);

    // zero on times and no cycle: phase stays 0, on and off every tick
    write_reg(REG_ON_TIMES, 64'd0);
    write_reg(REG_CYCLE_LENGTHS, 64'd0);
    random_phase(REQUESTS_PER_PHASE);

    // all ones: longest on time and cycle everywhere
    write_reg(REG_ON_TIMES, '1);
    write_reg(REG_CYCLE_LENGTHS, '1);
    random_phase(REQUESTS_PER_PHASE);

    write_reg(REG_ON_TIMES, {$urandom, $urandom});
    write_reg(REG_CYCLE_LENGTHS, {$urandom, $urandom});
    random_phase(REQUESTS_PER_PHASE);

    // short cycles so phases wrap often and on time may pass the cycle
    for (int k = 0; k < 8; k++) begin
      on_word[8*k +: 8]    = 8'($urandom_range(0, 4));
      cycle_word[8*k +: 8] = 8'($urandom_range(0, 6));
    end
    write_reg(REG_ON_TIMES, on_word);
    write_reg(REG_CYCLE_LENGTHS, cycle_word);
    random_phase(REQUESTS_PER_PHASE);

    in_valid = 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
    if (errors == 0 && pending == 0) begin
      $display("PASS multi_channel_blink_pattern_generator_core");
    end else begin
      $display("FAIL multi_channel_blink_pattern_generator_core");
    end
    $finish;
  end

endmodule

`default_nettype wire
